@@ src/ookpw_pkg.sv @@
// Package for the OOK pulse-width packet receiver.
// Holds sizes, codes and the result beat type that the receiver modules share.
// No dependencies.
package ookpw_pkg;

   localparam int MAX_PULSES   = 500;
   localparam int PACKET_BITS  = 88;
   localparam int PACKET_BYTES = PACKET_BITS / 8;

   localparam int CNT_W     = $clog2(MAX_PULSES);
   localparam int BIT_AW    = $clog2(PACKET_BITS);
   localparam int BYTE_AW   = $clog2(PACKET_BYTES);
   localparam int CFG_W     = 20;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam int CRC_FIRST_BIT = 8;
   localparam int CRC_END_BIT   = PACKET_BITS - 8;

   localparam logic [CNT_W-1:0]  SHORT_BURST_LIMIT = CNT_W'(60);
   localparam logic [TIME_W-1:0] STAT_RESET        = 32'd999999;
   localparam logic [CFG_W-1:0]  INIT_THR_RESET    = 20'd1000;
   localparam logic [CFG_W-1:0]  GAP_LIMIT_RESET   = 20'd5000;
   localparam logic [7:0]        CRC_POLY          = 8'h31;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = 2'd1;

   localparam logic [1:0] STAT_SHORT    = 2'd0;
   localparam logic [1:0] STAT_BAD_LEN  = 2'd1;
   localparam logic [1:0] STAT_CRC_OK   = 2'd2;
   localparam logic [1:0] STAT_CRC_FAIL = 2'd3;

   typedef logic alu_op_type;
   localparam alu_op_type ALU_ADD = 1'b0;
   localparam alu_op_type ALU_SUB = 1'b1;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        byte_value;
      logic [3:0]        byte_index;
      logic              last;
      logic [CNT_W-1:0]  pulse_count;
      logic [TIME_W-1:0] threshold_now;
   } rsp_item_type;

endpackage

@@ src/ookpw_alu.sv @@
// Shared 33-bit add/subtract unit of the receiver.
// On subtract, bit 32 of the result is the borrow (a below b).
// Depends on ookpw_pkg.
module ookpw_alu (
   input  ookpw_pkg::alu_op_type          op,
   input  logic [ookpw_pkg::TIME_W-1:0]   a,
   input  logic [ookpw_pkg::TIME_W-1:0]   b,
   output logic [ookpw_pkg::TIME_W:0]     result
);

   logic [ookpw_pkg::TIME_W:0] a_ext;
   logic [ookpw_pkg::TIME_W:0] b_ext;

   assign a_ext = {1'b0, a};
   assign b_ext = {1'b0, b};

   always_comb begin
      unique case (op)
         ookpw_pkg::ALU_ADD: result = a_ext + b_ext;
         default:            result = a_ext - b_ext;
      endcase
   end

endmodule

@@ src/ookpw_out.sv @@
// Result output register of the receiver: one beat held toward the master side.
// Packs the result item onto tdata, tuser and tlast. Depends on ookpw_pkg.
module ookpw_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ookpw_pkg::rsp_item_type item,
   output logic                    can_push,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // byte_value [7:0], byte_index [11:8], pulse_count [20:12], threshold_now [52:21]
   output logic [55:0]             rsp_tdata,
   // status [1:0]
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   logic                    vld_ff;
   logic                    vld_in;
   ookpw_pkg::rsp_item_type item_ff;

   assign can_push = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      if (push && can_push) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && can_push) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = item_ff.status;
   assign rsp_tlast  = item_ff.last;
   assign rsp_tdata  = {3'b000, item_ff.threshold_now, 9'(item_ff.pulse_count),
                        item_ff.byte_index, item_ff.byte_value};

endmodule

@@ src/ook_pulse_width_packet_receiver_top.sv @@
// Top level of the OOK pulse-width packet receiver: sequencer, state and bit store.
// Uses ookpw_alu as the one arithmetic unit and ookpw_out as result register.
// Depends on ookpw_pkg.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | req_tdata: line_level, time_us
//   rsp     | out | rsp_tvalid/tready  | rsp_tdata, rsp_tuser (status), rsp_tlast
//   csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// Samples with no edge or a rising edge pass S_GSUB and S_GCMP, a falling edge S_WIDTH
// to S_MAX first, all via the one shared add/subtract unit. A burst end of 88 pulses
// reads the stored bits one at a time through the bit store's port, then S_CHK, S_SUM
// on a CRC match and S_EMIT, one beat per byte; other burst ends give one S_STAT beat.
// req_tready is low meanwhile. Reset is synchronous; no clearing pass. A stalled rsp
// side holds the sequencer only while it has a beat to push; csr is always ready.
module ook_pulse_width_packet_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // line_level [0], time_us [32:1]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_value [7:0], byte_index [11:8], pulse_count [20:12], threshold_now [52:21]
   output logic [55:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int TW  = ookpw_pkg::TIME_W;
   localparam int CW  = ookpw_pkg::CNT_W;
   localparam int AW  = ookpw_pkg::BIT_AW;
   localparam int YW  = ookpw_pkg::BYTE_AW;
   localparam int NB  = ookpw_pkg::PACKET_BYTES;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WIDTH = 4'd1;
   localparam logic [3:0] S_CLASS = 4'd2;
   localparam logic [3:0] S_MIN   = 4'd3;
   localparam logic [3:0] S_MAX   = 4'd4;
   localparam logic [3:0] S_GSUB  = 4'd5;
   localparam logic [3:0] S_GCMP  = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_BIT   = 4'd8;
   localparam logic [3:0] S_CHK   = 4'd9;
   localparam logic [3:0] S_SUM   = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;
   localparam logic [3:0] S_STAT  = 4'd12;

   logic [3:0]  state_ff, state_in;

   logic [ookpw_pkg::CFG_W-1:0] init_thr_ff, init_thr_in;
   logic [ookpw_pkg::CFG_W-1:0] gap_limit_ff, gap_limit_in;

   logic          prev_level_ff, prev_level_in;
   logic [TW-1:0] last_edge_ff, last_edge_in;
   logic          armed_ff, armed_in;
   logic [CW-1:0] total_ff, total_in;
   logic [TW-1:0] min_short_ff, min_short_in;
   logic [TW-1:0] max_short_ff, max_short_in;
   logic [TW-1:0] min_long_ff, min_long_in;
   logic [TW-1:0] max_long_ff, max_long_in;
   logic [TW-1:0] thr_ff, thr_in;

   logic          level_ff, level_in;
   logic [TW-1:0] now_ff, now_in;
   logic [TW-1:0] width_ff, width_in;
   logic          short_ff, short_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    crc_ff, crc_in;
   logic          ok_ff, ok_in;
   logic [YW-1:0] emit_idx_ff, emit_idx_in;

   logic          bit_mem [ookpw_pkg::PACKET_BITS];
   logic          mem_we;
   logic          mem_wbit;
   logic          rdata_ff;

   logic [7:0]    byte_buf [NB];
   logic          buf_we;
   logic [7:0]    buf_wdata;

   ookpw_pkg::alu_op_type alu_op;
   logic [TW-1:0]         alu_a;
   logic [TW-1:0]         alu_b;
   logic [TW:0]           alu_res;
   logic                  borrow;

   logic                    push;
   logic                    can_push;
   ookpw_pkg::rsp_item_type item;
   logic                    req_fire;
   logic [7:0]              next_byte;
   logic                    crc_top;

   ookpw_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_res)
   );

   ookpw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .item       (item),
      .can_push   (can_push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign borrow     = alu_res[TW];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign next_byte  = {shift_ff[6:0], rdata_ff};
   assign crc_top    = crc_ff[7] ^ rdata_ff;

   always_comb begin
      state_in      = state_ff;
      init_thr_in   = init_thr_ff;
      gap_limit_in  = gap_limit_ff;
      prev_level_in = prev_level_ff;
      last_edge_in  = last_edge_ff;
      armed_in      = armed_ff;
      total_in      = total_ff;
      min_short_in  = min_short_ff;
      max_short_in  = max_short_ff;
      min_long_in   = min_long_ff;
      max_long_in   = max_long_ff;
      thr_in        = thr_ff;
      level_in      = level_ff;
      now_in        = now_ff;
      width_in      = width_ff;
      short_in      = short_ff;
      rd_addr_in    = rd_addr_ff;
      shift_in      = shift_ff;
      crc_in        = crc_ff;
      ok_in         = ok_ff;
      emit_idx_in   = emit_idx_ff;
      mem_we        = 1'b0;
      mem_wbit      = 1'b0;
      buf_we        = 1'b0;
      buf_wdata     = next_byte;
      alu_op        = ookpw_pkg::ALU_SUB;
      alu_a         = '0;
      alu_b         = '0;
      push          = 1'b0;
      item.status        = ookpw_pkg::STAT_SHORT;
      item.byte_value    = '0;
      item.byte_index    = '0;
      item.last          = 1'b1;
      item.pulse_count   = total_ff;
      item.threshold_now = thr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               level_in = req_tdata[0];
               now_in   = req_tdata[32:1];
               if (req_tdata[0] != prev_level_ff && !req_tdata[0]) begin
                  state_in = S_WIDTH;
               end else begin
                  if (req_tdata[0] != prev_level_ff) begin
                     prev_level_in = 1'b1;
                     last_edge_in  = req_tdata[32:1];
                     armed_in      = 1'b1;
                  end
                  state_in = S_GSUB;
               end
            end
         end
         S_WIDTH: begin
            alu_a         = now_ff;
            alu_b         = last_edge_ff;
            width_in      = alu_res[TW-1:0];
            prev_level_in = level_ff;
            last_edge_in  = now_ff;
            armed_in      = 1'b1;
            state_in      = S_CLASS;
         end
         S_CLASS: begin
            alu_a    = width_ff;
            alu_b    = thr_ff;
            short_in = borrow;
            mem_wbit = borrow;
            mem_we   = (32'(total_ff) < ookpw_pkg::PACKET_BITS);
            if (32'(total_ff) < ookpw_pkg::MAX_PULSES - 1) begin
               state_in = S_MIN;
            end else begin
               state_in = S_GSUB;
            end
         end
         S_MIN: begin
            alu_a = width_ff;
            alu_b = short_ff ? min_short_ff : min_long_ff;
            if (borrow) begin
               if (short_ff) begin
                  min_short_in = width_ff;
               end else begin
                  min_long_in = width_ff;
               end
            end
            state_in = S_MAX;
         end
         S_MAX: begin
            alu_a = short_ff ? max_short_ff : max_long_ff;
            alu_b = width_ff;
            if (borrow) begin
               if (short_ff) begin
                  max_short_in = width_ff;
               end else begin
                  max_long_in = width_ff;
               end
            end
            total_in = total_ff + CW'(1);
            state_in = S_GSUB;
         end
         S_GSUB: begin
            alu_a    = now_ff;
            alu_b    = last_edge_ff;
            width_in = alu_res[TW-1:0];
            state_in = S_GCMP;
         end
         S_GCMP: begin
            alu_a = TW'(gap_limit_ff);
            alu_b = width_ff;
            if (armed_ff && borrow) begin
               if (total_ff > ookpw_pkg::SHORT_BURST_LIMIT &&
                   32'(total_ff) == ookpw_pkg::PACKET_BITS) begin
                  rd_addr_in = '0;
                  crc_in     = '0;
                  state_in   = S_RD;
               end else begin
                  state_in = S_STAT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_BIT;
         end
         S_BIT: begin
            shift_in = next_byte;
            if (32'(rd_addr_ff) >= ookpw_pkg::CRC_FIRST_BIT &&
                32'(rd_addr_ff) < ookpw_pkg::CRC_END_BIT) begin
               crc_in = {crc_ff[6:0], 1'b0} ^ (crc_top ? ookpw_pkg::CRC_POLY : 8'h00);
            end
            buf_we = (rd_addr_ff[2:0] == 3'd7);
            if (32'(rd_addr_ff) == ookpw_pkg::PACKET_BITS - 1) begin
               state_in = S_CHK;
            end else begin
               rd_addr_in = rd_addr_ff + AW'(1);
               state_in   = S_RD;
            end
         end
         S_CHK: begin
            ok_in       = (byte_buf[NB-1] == crc_ff);
            emit_idx_in = '0;
            state_in    = (byte_buf[NB-1] == crc_ff) ? S_SUM : S_EMIT;
         end
         S_SUM: begin
            alu_op   = ookpw_pkg::ALU_ADD;
            alu_a    = max_short_ff;
            alu_b    = min_long_ff;
            thr_in   = alu_res[TW:1];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            push            = 1'b1;
            item.status     = ok_ff ? ookpw_pkg::STAT_CRC_OK : ookpw_pkg::STAT_CRC_FAIL;
            item.byte_value = byte_buf[emit_idx_ff];
            item.byte_index = 4'(emit_idx_ff);
            item.last       = (32'(emit_idx_ff) == NB - 1);
            if (can_push) begin
               if (32'(emit_idx_ff) == NB - 1) begin
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + YW'(1);
               end
            end
         end
         S_STAT: begin
            push        = 1'b1;
            item.status = (total_ff > ookpw_pkg::SHORT_BURST_LIMIT) ?
                          ookpw_pkg::STAT_BAD_LEN : ookpw_pkg::STAT_SHORT;
            if (can_push) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // burst end: clear statistics once the last beat is handed over
      if (push && can_push && item.last) begin
         min_short_in = ookpw_pkg::STAT_RESET;
         max_short_in = '0;
         min_long_in  = ookpw_pkg::STAT_RESET;
         max_long_in  = '0;
         total_in     = '0;
         armed_in     = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ookpw_pkg::CSR_INIT_THR: begin
               init_thr_in = csr_data;
               thr_in      = TW'(csr_data);
            end
            ookpw_pkg::CSR_GAP: begin
               gap_limit_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         init_thr_ff   <= ookpw_pkg::INIT_THR_RESET;
         gap_limit_ff  <= ookpw_pkg::GAP_LIMIT_RESET;
         prev_level_ff <= 1'b0;
         last_edge_ff  <= '0;
         armed_ff      <= 1'b0;
         total_ff      <= '0;
         min_short_ff  <= ookpw_pkg::STAT_RESET;
         max_short_ff  <= '0;
         min_long_ff   <= ookpw_pkg::STAT_RESET;
         max_long_ff   <= '0;
         thr_ff        <= TW'(ookpw_pkg::INIT_THR_RESET);
      end else begin
         state_ff      <= state_in;
         init_thr_ff   <= init_thr_in;
         gap_limit_ff  <= gap_limit_in;
         prev_level_ff <= prev_level_in;
         last_edge_ff  <= last_edge_in;
         armed_ff      <= armed_in;
         total_ff      <= total_in;
         min_short_ff  <= min_short_in;
         max_short_ff  <= max_short_in;
         min_long_ff   <= min_long_in;
         max_long_ff   <= max_long_in;
         thr_ff        <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      now_ff      <= now_in;
      width_ff    <= width_in;
      short_ff    <= short_in;
      rd_addr_ff  <= rd_addr_in;
      shift_ff    <= shift_in;
      crc_ff      <= crc_in;
      ok_ff       <= ok_in;
      emit_idx_ff <= emit_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bit_mem[total_ff[AW-1:0]] <= mem_wbit;
      end
      rdata_ff <= bit_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         byte_buf[rd_addr_ff[AW-1:3]] <= buf_wdata;
      end
   end

endmodule
